// ===== design/stok_pkg.sv =====
// Shared types, constants and character-class functions of the script tokenizer.
// Used by stok_core, script_tokenizer and stok_checker; depends on nothing else.

package stok_pkg;

   localparam int OFFSET_WIDTH  = 24;
   localparam int LINE_WIDTH    = 16;
   localparam int KEYWORD_BYTES = 8;
   localparam int WLEN_WIDTH    = $clog2(KEYWORD_BYTES + 1);
   localparam int WIDX_WIDTH    = $clog2(KEYWORD_BYTES);
   localparam int KIND_WIDTH    = 6;
   localparam int ERR_WIDTH     = 2;
   localparam int CHAR_WIDTH    = 8;
   localparam int NUM_KEYWORDS  = 14;
   localparam int KW_TEXT_BYTES = 8;

   typedef logic [KIND_WIDTH-1:0] kind_type;
   typedef logic [ERR_WIDTH-1:0]  err_type;
   typedef logic [CHAR_WIDTH-1:0] char_type;

   // Token kinds.
   localparam kind_type KIND_EOF       = 6'd0;
   localparam kind_type KIND_INT       = 6'd1;
   localparam kind_type KIND_FLOAT     = 6'd2;
   localparam kind_type KIND_ID        = 6'd3;
   localparam kind_type KIND_STRING    = 6'd4;
   localparam kind_type KIND_KW_BASE   = 6'd5;
   localparam kind_type KIND_LPAREN    = 6'd19;
   localparam kind_type KIND_RPAREN    = 6'd20;
   localparam kind_type KIND_LBRACE    = 6'd21;
   localparam kind_type KIND_RBRACE    = 6'd22;
   localparam kind_type KIND_LBRACKET  = 6'd23;
   localparam kind_type KIND_RBRACKET  = 6'd24;
   localparam kind_type KIND_DOT       = 6'd25;
   localparam kind_type KIND_COMMA     = 6'd26;
   localparam kind_type KIND_COLON     = 6'd27;
   localparam kind_type KIND_SEMICOLON = 6'd28;
   localparam kind_type KIND_PLUS      = 6'd29;
   localparam kind_type KIND_INCR      = 6'd30;
   localparam kind_type KIND_PLUS_EQ   = 6'd31;
   localparam kind_type KIND_MINUS     = 6'd32;
   localparam kind_type KIND_ARROW     = 6'd33;
   localparam kind_type KIND_DECR      = 6'd34;
   localparam kind_type KIND_MINUS_EQ  = 6'd35;
   localparam kind_type KIND_STAR      = 6'd36;
   localparam kind_type KIND_SLASH     = 6'd38;
   localparam kind_type KIND_PERCENT   = 6'd40;
   localparam kind_type KIND_CARET     = 6'd42;
   localparam kind_type KIND_ASSIGN    = 6'd44;
   localparam kind_type KIND_FAT_ARROW = 6'd45;
   localparam kind_type KIND_EQUAL     = 6'd46;
   localparam kind_type KIND_BANG      = 6'd47;
   localparam kind_type KIND_LESS      = 6'd49;
   localparam kind_type KIND_GREATER   = 6'd51;
   localparam kind_type KIND_LINE_CMT  = 6'd53;
   localparam kind_type KIND_BLOCK_CMT = 6'd54;
   localparam kind_type KIND_ERROR     = 6'd55;
   localparam kind_type KIND_NONE      = 6'd0;

   // Error codes.
   localparam err_type ERR_NONE    = 2'd0;
   localparam err_type ERR_CHAR    = 2'd1;
   localparam err_type ERR_STRING  = 2'd2;
   localparam err_type ERR_COMMENT = 2'd3;

   // Characters with a role of their own.
   localparam char_type CH_BACKSLASH  = 8'h5C;
   localparam char_type CH_QUOTE      = 8'h22;
   localparam char_type CH_UNDERSCORE = 8'h5F;
   localparam char_type CH_DOT        = 8'h2E;
   localparam char_type CH_NEWLINE    = 8'h0A;
   localparam char_type CH_STAR       = 8'h2A;
   localparam char_type CH_SLASH      = 8'h2F;
   localparam char_type CH_EQUALS     = 8'h3D;
   localparam char_type CH_PLUS       = 8'h2B;
   localparam char_type CH_MINUS      = 8'h2D;
   localparam char_type CH_GREATER    = 8'h3E;
   localparam char_type CH_SPACE      = 8'h20;

   typedef enum logic [3:0] {
      MODE_IDLE  = 4'd0,
      MODE_INT   = 4'd1,
      MODE_FLOAT = 4'd2,
      MODE_WORD  = 4'd3,
      MODE_LONG  = 4'd4,
      MODE_STR   = 4'd5,
      MODE_ESC   = 4'd6,
      MODE_OP    = 4'd7,
      MODE_LINE  = 4'd8,
      MODE_BLOCK = 4'd9,
      MODE_STAR  = 4'd10
   } scan_mode_type;

   typedef struct packed {
      logic     valid;
      char_type char_byte;
      logic     end_marker;
   } item_type;

   typedef struct packed {
      kind_type                kind;
      logic [OFFSET_WIDTH-1:0] start_offset;
      logic [OFFSET_WIDTH-1:0] length;
      logic [LINE_WIDTH-1:0]   line;
      logic [LINE_WIDTH-1:0]   column;
      err_type                 err;
   } token_type;

   typedef struct packed {
      logic      valid;
      token_type token;
   } emit_type;

   // Keyword text is right-justified: the last character sits in the low byte.
   localparam logic [8*KW_TEXT_BYTES-1:0] KW_TEXT [NUM_KEYWORDS] = '{
      "if", "else", "for", "loop", "while", "break", "continue",
      "fn", "return", "false", "true", "and", "or", "xor"
   };
   localparam int KW_LEN [NUM_KEYWORDS] = '{2, 4, 3, 4, 5, 5, 8, 2, 6, 5, 4, 3, 2, 3};

   function automatic char_type kw_char(input int k, input int i);
      char_type ch;
      ch = '0;
      if (i < KW_LEN[k]) begin
         ch = KW_TEXT[k][8*(KW_LEN[k]-1-i) +: 8];
      end
      return ch;
   endfunction

   // Keyword lookup over the buffered word; anything else is an identifier.
   function automatic kind_type word_kind(input logic [8*KEYWORD_BYTES-1:0] word,
                                          input logic [WLEN_WIDTH-1:0] len);
      kind_type kind;
      logic     hit;
      kind = KIND_ID;
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
         hit = (len == WLEN_WIDTH'(KW_LEN[k]));
         for (int i = 0; i < KEYWORD_BYTES; i++) begin
            if (i < KW_LEN[k] && word[8*i +: 8] != kw_char(k, i)) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            kind = KIND_KW_BASE + KIND_WIDTH'(k);
         end
      end
      return kind;
   endfunction

   function automatic logic is_digit(input char_type c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(input char_type c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_word(input char_type c);
      return is_alpha(c) || is_digit(c) || c == CH_UNDERSCORE;
   endfunction

   function automatic logic is_space(input char_type c);
      return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic kind_type single_kind(input char_type c);
      kind_type kind;
      unique case (c)
         "(":     kind = KIND_LPAREN;
         ")":     kind = KIND_RPAREN;
         "{":     kind = KIND_LBRACE;
         "}":     kind = KIND_RBRACE;
         "[":     kind = KIND_LBRACKET;
         "]":     kind = KIND_RBRACKET;
         ".":     kind = KIND_DOT;
         ",":     kind = KIND_COMMA;
         ":":     kind = KIND_COLON;
         ";":     kind = KIND_SEMICOLON;
         default: kind = KIND_NONE;
      endcase
      return kind;
   endfunction

   function automatic kind_type op_kind(input char_type c);
      kind_type kind;
      unique case (c)
         "+":     kind = KIND_PLUS;
         "-":     kind = KIND_MINUS;
         "*":     kind = KIND_STAR;
         "/":     kind = KIND_SLASH;
         "%":     kind = KIND_PERCENT;
         "^":     kind = KIND_CARET;
         "=":     kind = KIND_ASSIGN;
         "!":     kind = KIND_BANG;
         "<":     kind = KIND_LESS;
         ">":     kind = KIND_GREATER;
         default: kind = KIND_NONE;
      endcase
      return kind;
   endfunction

   // Kind of the two-byte operator formed by p then c, or KIND_NONE.
   function automatic kind_type pair_kind(input char_type p, input char_type c);
      kind_type kind;
      kind = KIND_NONE;
      if (p == CH_PLUS) begin
         if (c == CH_PLUS) kind = KIND_INCR;
         else if (c == CH_EQUALS) kind = KIND_PLUS_EQ;
      end else if (p == CH_MINUS) begin
         if (c == CH_GREATER) kind = KIND_ARROW;
         else if (c == CH_MINUS) kind = KIND_DECR;
         else if (c == CH_EQUALS) kind = KIND_MINUS_EQ;
      end else if (p == CH_EQUALS) begin
         if (c == CH_GREATER) kind = KIND_FAT_ARROW;
         else if (c == CH_EQUALS) kind = KIND_EQUAL;
      end else if (op_kind(p) != KIND_NONE && c == CH_EQUALS) begin
         // The compound form always follows its single-byte kind.
         kind = op_kind(p) + KIND_WIDTH'(1);
      end
      return kind;
   endfunction

endpackage

// ===== design/script_tokenizer.sv =====
// Top level of the script tokenizer: input register, scanner core, result buffer.
// Depends on stok_pkg and stok_core.
//
//   channel | direction | tdata                                 | tuser            | tlast
//   req_    | in        | char_byte[7:0]                        | -                | end_marker
//   rsp_    | out       | start_offset, token_length, line, col | token_kind, err  | last_of_run
//
// An accepted byte is registered, then scanned by the core; one byte per cycle is
// sustained while each byte yields at most one token and the result side is ready.
// A byte yielding two tokens holds back the next token-yielding byte, since the result
// buffer delivers one token per cycle. Reset is synchronous and returns the scanner
// to offset 0, line 1, column 1. Stalls on either side lose nothing.

module script_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_byte
   input  logic        req_tlast,   // end_marker
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [23:0] start_offset, [47:24] token_length,
                                    // [63:48] start_line, [79:64] start_column
   output logic [7:0]  rsp_tuser,   // [5:0] token_kind, [7:6] error_code
   output logic        rsp_tlast    // last_of_run
);

   logic               in_valid_ff;
   stok_pkg::char_type in_char_ff;
   logic               in_end_ff;
   stok_pkg::item_type item;
   stok_pkg::emit_type emit_a;
   stok_pkg::emit_type emit_b;

   logic [1:0]          cnt_ff, cnt_in;
   stok_pkg::token_type head_ff, head_in;
   stok_pkg::token_type tail_ff, tail_in;
   logic                head_last_ff, head_last_in;

   logic out_free;
   logic any_emit;
   logic step;
   logic take;

   assign item.valid      = in_valid_ff;
   assign item.char_byte  = in_char_ff;
   assign item.end_marker = in_end_ff;

   stok_core u_core (
      .clock  (clock),
      .reset  (reset),
      .item   (item),
      .step   (step),
      .emit_a (emit_a),
      .emit_b (emit_b)
   );

   assign take       = rsp_tvalid && rsp_tready;
   assign out_free   = cnt_ff == 2'd0 || (cnt_ff == 2'd1 && rsp_tready);
   assign any_emit   = emit_a.valid || emit_b.valid;
   assign step       = in_valid_ff && (out_free || !any_emit);
   assign req_tready = !in_valid_ff || step;

   always_comb begin
      cnt_in       = cnt_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      head_last_in = head_last_ff;
      if (step && any_emit) begin
         if (emit_a.valid && emit_b.valid) begin
            head_in      = emit_a.token;
            tail_in      = emit_b.token;
            head_last_in = 1'b0;
            cnt_in       = 2'd2;
         end else begin
            head_in      = emit_a.valid ? emit_a.token : emit_b.token;
            head_last_in = 1'b1;
            cnt_in       = 2'd1;
         end
      end else if (take) begin
         if (cnt_ff == 2'd2) begin
            head_in      = tail_ff;
            head_last_in = 1'b1;
            cnt_in       = 2'd1;
         end else begin
            cnt_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         cnt_ff      <= 2'd0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
      head_ff      <= head_in;
      tail_ff      <= tail_in;
      head_last_ff <= head_last_in;
   end

   assign rsp_tvalid = cnt_ff != 2'd0;
   assign rsp_tdata  = {head_ff.column, head_ff.line, head_ff.length, head_ff.start_offset};
   assign rsp_tuser  = {head_ff.err, head_ff.kind};
   assign rsp_tlast  = head_last_ff;

endmodule

// ===== design/stok_core.sv =====
// Scanner state and per-byte step logic of the script tokenizer.
// Depends on stok_pkg. Produces up to two tokens per input transaction.

module stok_core (
   input  logic               clock,
   input  logic               reset,
   input  stok_pkg::item_type item,
   input  logic               step,
   output stok_pkg::emit_type emit_a,
   output stok_pkg::emit_type emit_b
);

   stok_pkg::scan_mode_type mode_ff, mode_in;
   stok_pkg::char_type      pend_ff, pend_in;
   logic [stok_pkg::OFFSET_WIDTH-1:0] tstart_ff, tstart_in;
   logic [stok_pkg::LINE_WIDTH-1:0]   tline_ff, tline_in;
   logic [stok_pkg::LINE_WIDTH-1:0]   tcol_ff, tcol_in;
   logic [stok_pkg::OFFSET_WIDTH-1:0] off_ff, off_in;
   logic [stok_pkg::LINE_WIDTH-1:0]   line_ff, line_in;
   logic [stok_pkg::LINE_WIDTH-1:0]   col_ff, col_in;
   logic [8*stok_pkg::KEYWORD_BYTES-1:0] wbuf_ff, wbuf_in;
   logic [stok_pkg::WLEN_WIDTH-1:0]   wlen_ff, wlen_in;

   stok_pkg::char_type c;
   stok_pkg::kind_type pair;
   stok_pkg::kind_type single;
   stok_pkg::kind_type close_kind;
   stok_pkg::err_type  close_err;
   logic [stok_pkg::OFFSET_WIDTH-1:0] span;
   logic [stok_pkg::OFFSET_WIDTH-1:0] span_inc;
   logic fresh;
   logic slash_open;
   logic starts_word;
   logic starts_op;
   logic starts_emit;

   assign c          = item.char_byte;
   assign pair       = stok_pkg::pair_kind(pend_ff, c);
   assign single     = stok_pkg::single_kind(c);
   assign span       = off_ff - tstart_ff;
   assign span_inc   = span + stok_pkg::OFFSET_WIDTH'(1);
   assign slash_open = pend_ff == stok_pkg::CH_SLASH &&
                       (c == stok_pkg::CH_STAR || c == stok_pkg::CH_SLASH);

   assign starts_word = stok_pkg::is_alpha(c) || c == stok_pkg::CH_UNDERSCORE;
   assign starts_op   = single == stok_pkg::KIND_NONE &&
                        stok_pkg::op_kind(c) != stok_pkg::KIND_NONE;
   // A byte that opens no multi-byte token yields a token right away:
   // a punctuation mark, or an unexpected character.
   assign starts_emit = !stok_pkg::is_space(c) && !stok_pkg::is_digit(c) && !starts_word &&
                        c != stok_pkg::CH_QUOTE && !starts_op;

   // Does this byte end the open token and begin a new one?
   always_comb begin
      unique case (mode_ff)
         stok_pkg::MODE_IDLE:  fresh = 1'b1;
         stok_pkg::MODE_INT:   fresh = c != stok_pkg::CH_DOT && !stok_pkg::is_digit(c);
         stok_pkg::MODE_FLOAT: fresh = !stok_pkg::is_digit(c);
         stok_pkg::MODE_WORD,
         stok_pkg::MODE_LONG:  fresh = !stok_pkg::is_word(c);
         stok_pkg::MODE_OP:    fresh = pair == stok_pkg::KIND_NONE && !slash_open;
         default:              fresh = 1'b0;
      endcase
   end

   // Token that the open mode turns into when it is cut off.
   always_comb begin
      close_err = stok_pkg::ERR_NONE;
      unique case (mode_ff)
         stok_pkg::MODE_INT:   close_kind = stok_pkg::KIND_INT;
         stok_pkg::MODE_FLOAT: close_kind = stok_pkg::KIND_FLOAT;
         stok_pkg::MODE_WORD:  close_kind = stok_pkg::word_kind(wbuf_ff, wlen_ff);
         stok_pkg::MODE_LONG:  close_kind = stok_pkg::KIND_ID;
         stok_pkg::MODE_OP:    close_kind = stok_pkg::op_kind(pend_ff);
         stok_pkg::MODE_LINE:  close_kind = stok_pkg::KIND_LINE_CMT;
         stok_pkg::MODE_STR,
         stok_pkg::MODE_ESC: begin
            close_kind = stok_pkg::KIND_ERROR;
            close_err  = stok_pkg::ERR_STRING;
         end
         stok_pkg::MODE_BLOCK,
         stok_pkg::MODE_STAR: begin
            close_kind = stok_pkg::KIND_ERROR;
            close_err  = stok_pkg::ERR_COMMENT;
         end
         default: close_kind = stok_pkg::KIND_NONE;
      endcase
   end

   // Next state.
   always_comb begin
      mode_in   = mode_ff;
      pend_in   = pend_ff;
      tstart_in = tstart_ff;
      tline_in  = tline_ff;
      tcol_in   = tcol_ff;
      wbuf_in   = wbuf_ff;
      wlen_in   = wlen_ff;
      off_in    = off_ff + stok_pkg::OFFSET_WIDTH'(1);
      line_in   = line_ff;
      col_in    = col_ff + stok_pkg::LINE_WIDTH'(1);
      if (item.end_marker) begin
         // End of text: everything returns to the start of a new text.
         mode_in   = stok_pkg::MODE_IDLE;
         pend_in   = '0;
         tstart_in = '0;
         tline_in  = stok_pkg::LINE_WIDTH'(1);
         tcol_in   = stok_pkg::LINE_WIDTH'(1);
         wlen_in   = '0;
         off_in    = '0;
         line_in   = stok_pkg::LINE_WIDTH'(1);
         col_in    = stok_pkg::LINE_WIDTH'(1);
      end else begin
         if (c == stok_pkg::CH_NEWLINE) begin
            line_in = line_ff + stok_pkg::LINE_WIDTH'(1);
            col_in  = stok_pkg::LINE_WIDTH'(1);
         end
         if (fresh) begin
            tstart_in = off_ff;
            tline_in  = line_ff;
            tcol_in   = col_ff;
            mode_in   = stok_pkg::MODE_IDLE;
            if (stok_pkg::is_digit(c)) begin
               mode_in = stok_pkg::MODE_INT;
            end else if (starts_word) begin
               mode_in     = stok_pkg::MODE_WORD;
               wbuf_in[7:0] = c;
               wlen_in     = stok_pkg::WLEN_WIDTH'(1);
            end else if (c == stok_pkg::CH_QUOTE) begin
               mode_in = stok_pkg::MODE_STR;
            end else if (starts_op) begin
               mode_in = stok_pkg::MODE_OP;
               pend_in = c;
            end
         end else begin
            unique case (mode_ff)
               stok_pkg::MODE_INT: begin
                  if (c == stok_pkg::CH_DOT) mode_in = stok_pkg::MODE_FLOAT;
               end
               stok_pkg::MODE_WORD: begin
                  if (wlen_ff < stok_pkg::WLEN_WIDTH'(stok_pkg::KEYWORD_BYTES)) begin
                     wbuf_in[8*wlen_ff[stok_pkg::WIDX_WIDTH-1:0] +: 8] = c;
                     wlen_in = wlen_ff + stok_pkg::WLEN_WIDTH'(1);
                  end else begin
                     mode_in = stok_pkg::MODE_LONG;
                  end
               end
               stok_pkg::MODE_STR: begin
                  if (c == stok_pkg::CH_QUOTE) mode_in = stok_pkg::MODE_IDLE;
                  else if (c == stok_pkg::CH_BACKSLASH) mode_in = stok_pkg::MODE_ESC;
               end
               stok_pkg::MODE_ESC: mode_in = stok_pkg::MODE_STR;
               stok_pkg::MODE_OP: begin
                  if (pend_ff == stok_pkg::CH_SLASH && c == stok_pkg::CH_STAR) begin
                     mode_in = stok_pkg::MODE_BLOCK;
                  end else if (pend_ff == stok_pkg::CH_SLASH && c == stok_pkg::CH_SLASH) begin
                     mode_in = stok_pkg::MODE_LINE;
                  end else begin
                     mode_in = stok_pkg::MODE_IDLE;
                  end
               end
               stok_pkg::MODE_LINE: begin
                  if (c == stok_pkg::CH_NEWLINE) mode_in = stok_pkg::MODE_IDLE;
               end
               stok_pkg::MODE_BLOCK: begin
                  if (c == stok_pkg::CH_STAR) mode_in = stok_pkg::MODE_STAR;
               end
               stok_pkg::MODE_STAR: begin
                  if (c == stok_pkg::CH_SLASH) mode_in = stok_pkg::MODE_IDLE;
                  else if (c != stok_pkg::CH_STAR) mode_in = stok_pkg::MODE_BLOCK;
               end
               default: mode_in = mode_ff;
            endcase
         end
      end
   end

   // Outputs: the first token ends at or before this byte and keeps the saved
   // start position; the second starts at the current position.
   always_comb begin
      emit_a.valid              = 1'b0;
      emit_a.token.kind         = close_kind;
      emit_a.token.start_offset = tstart_ff;
      emit_a.token.length       = span;
      emit_a.token.line         = tline_ff;
      emit_a.token.column       = tcol_ff;
      emit_a.token.err          = close_err;

      emit_b.valid              = 1'b0;
      emit_b.token.kind         = stok_pkg::KIND_EOF;
      emit_b.token.start_offset = off_ff;
      emit_b.token.length       = '0;
      emit_b.token.line         = line_ff;
      emit_b.token.column       = col_ff;
      emit_b.token.err          = stok_pkg::ERR_NONE;

      if (item.end_marker) begin
         emit_a.valid = item.valid && mode_ff != stok_pkg::MODE_IDLE;
         emit_b.valid = item.valid;
      end else if (fresh) begin
         emit_a.valid        = item.valid && mode_ff != stok_pkg::MODE_IDLE;
         emit_b.valid        = item.valid && starts_emit;
         emit_b.token.length = stok_pkg::OFFSET_WIDTH'(1);
         if (single != stok_pkg::KIND_NONE) begin
            emit_b.token.kind = single;
         end else begin
            emit_b.token.kind = stok_pkg::KIND_ERROR;
            emit_b.token.err  = stok_pkg::ERR_CHAR;
         end
      end else begin
         emit_a.token.err = stok_pkg::ERR_NONE;
         unique case (mode_ff)
            stok_pkg::MODE_STR: begin
               emit_a.valid        = item.valid && c == stok_pkg::CH_QUOTE;
               emit_a.token.kind   = stok_pkg::KIND_STRING;
               emit_a.token.length = span_inc;
            end
            stok_pkg::MODE_OP: begin
               emit_a.valid        = item.valid && pair != stok_pkg::KIND_NONE;
               emit_a.token.kind   = pair;
               emit_a.token.length = stok_pkg::OFFSET_WIDTH'(2);
            end
            stok_pkg::MODE_LINE: begin
               emit_a.valid        = item.valid && c == stok_pkg::CH_NEWLINE;
               emit_a.token.kind   = stok_pkg::KIND_LINE_CMT;
               emit_a.token.length = span_inc;
            end
            stok_pkg::MODE_STAR: begin
               emit_a.valid        = item.valid && c == stok_pkg::CH_SLASH;
               emit_a.token.kind   = stok_pkg::KIND_BLOCK_CMT;
               emit_a.token.length = span_inc;
            end
            default: emit_a.valid = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= stok_pkg::MODE_IDLE;
         pend_ff   <= '0;
         tstart_ff <= '0;
         tline_ff  <= stok_pkg::LINE_WIDTH'(1);
         tcol_ff   <= stok_pkg::LINE_WIDTH'(1);
         off_ff    <= '0;
         line_ff   <= stok_pkg::LINE_WIDTH'(1);
         col_ff    <= stok_pkg::LINE_WIDTH'(1);
         wlen_ff   <= '0;
      end else if (step) begin
         mode_ff   <= mode_in;
         pend_ff   <= pend_in;
         tstart_ff <= tstart_in;
         tline_ff  <= tline_in;
         tcol_ff   <= tcol_in;
         off_ff    <= off_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         wlen_ff   <= wlen_in;
      end
   end

   // Only bytes of the current word are ever compared, so no reset here.
   always_ff @(posedge clock) begin
      if (step) begin
         wbuf_ff <= wbuf_in;
      end
   end

endmodule

// ===== design/stok_checker.sv =====
// Port-level checks for script_tokenizer, attached to it by the bind below.
// Depends on stok_pkg and on the port list of script_tokenizer.

module stok_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic [7:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // A stalled result transaction holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // The second token of a byte is already buffered when the first one leaves.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("second token of a byte missing");

   // Error codes travel only with the error kind.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[7:6] != stok_pkg::ERR_NONE |->
         rsp_tuser[5:0] == stok_pkg::KIND_ERROR)
      else $error("error code on a non-error token");

   // End of text closes the run with an empty token.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[5:0] == stok_pkg::KIND_EOF |->
         rsp_tlast && rsp_tdata[47:24] == '0)
      else $error("malformed end-of-text token");

endmodule

bind script_tokenizer stok_port_checks u_stok_checker (.*);
